// ===== hdl/snar_pkg.sv =====
// Shared types, codes and direction helpers for stick navigation with auto-repeat.
package snar_pkg;

    // Item opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SETNAV = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_HIDE   = 3'd3;
    localparam logic [2:0] OP_SCROLL = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAV_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEST_LOCKOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR   = 3'd4;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration reset values
    localparam logic [7:0]  RST_INIT_DELAY   = 8'd8;
    localparam logic [7:0]  RST_REPEAT_DELAY = 8'd3;
    localparam logic [7:0]  RST_NAV_TIMEOUT  = 8'd120;
    localparam logic [7:0]  RST_GEST_LOCKOUT = 8'd10;
    localparam logic [31:0] RST_MOTION_THR   = 32'd25165824; // 1.5 in Q8.24

    // Dense direction codes
    localparam logic [3:0] DIR_NONE  = 4'd0;
    localparam logic [3:0] DIR_UP    = 4'd1;
    localparam logic [3:0] DIR_UR    = 4'd2;
    localparam logic [3:0] DIR_RIGHT = 4'd3;
    localparam logic [3:0] DIR_DR    = 4'd4;
    localparam logic [3:0] DIR_DOWN  = 4'd5;
    localparam logic [3:0] DIR_DL    = 4'd6;
    localparam logic [3:0] DIR_LEFT  = 4'd7;
    localparam logic [3:0] DIR_UL    = 4'd8;

    typedef struct packed {
        logic [7:0]  init_delay;
        logic [7:0]  repeat_delay;
        logic [7:0]  nav_timeout;
        logic [7:0]  gest_lockout;
        logic [31:0] motion_thr;
    } t_cfg;

    // One item after the input register, with squared velocity magnitudes
    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  press_mask;
        logic [7:0]  held_mask;
        logic        enable_flag;
        logic        auto_return_off;
        logic [30:0] sq_x;
        logic [30:0] sq_y;
        logic        y_neg;
        logic        y_zero;
    } t_tick;

    // Held mask counts only when exactly one bit is set
    function automatic logic [3:0] dir_of_bit(input logic [7:0] bits);
        logic [3:0] d;
        case (bits)
            8'h01:   d = DIR_UP;
            8'h80:   d = DIR_UR;
            8'h40:   d = DIR_RIGHT;
            8'h20:   d = DIR_DR;
            8'h10:   d = DIR_DOWN;
            8'h08:   d = DIR_DL;
            8'h04:   d = DIR_LEFT;
            8'h02:   d = DIR_UL;
            default: d = DIR_NONE;
        endcase
        return d;
    endfunction

    // First pressed bit going clockwise from up
    function automatic logic [3:0] press_dir(input logic [7:0] press);
        logic [3:0] d;
        if (press[0])      d = DIR_UP;
        else if (press[7]) d = DIR_UR;
        else if (press[6]) d = DIR_RIGHT;
        else if (press[5]) d = DIR_DR;
        else if (press[4]) d = DIR_DOWN;
        else if (press[3]) d = DIR_DL;
        else if (press[2]) d = DIR_LEFT;
        else if (press[1]) d = DIR_UL;
        else               d = DIR_NONE;
        return d;
    endfunction

endpackage

// ===== hdl/snar_in_if.sv =====
// Input item channel: valid/ready handshake with the frame item payload.
interface snar_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [7:0]         press_mask;
    logic [7:0]         held_mask;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic               enable_flag;
    logic               auto_return_off;

    modport source (
        output valid, opcode, press_mask, held_mask, vel_x, vel_y,
               enable_flag, auto_return_off,
        input  ready
    );
    modport sink (
        input  valid, opcode, press_mask, held_mask, vel_x, vel_y,
               enable_flag, auto_return_off,
        output ready
    );
endinterface

// ===== hdl/snar_out_if.sv =====
// Result channel: valid/ready handshake with the navigation status payload.
interface snar_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] nav_event;
    logic [3:0] held_direction;
    logic       pointer_shown;
    logic       pointer_was_shown;
    logic       swing_left;
    logic       swing_right;
    logic       stick_cursor_shown;

    modport source (
        output valid, nav_event, held_direction, pointer_shown, pointer_was_shown,
               swing_left, swing_right, stick_cursor_shown,
        input  ready
    );
    modport sink (
        input  valid, nav_event, held_direction, pointer_shown, pointer_was_shown,
               swing_left, swing_right, stick_cursor_shown,
        output ready
    );
endinterface

// ===== hdl/snar_front.sv =====
// Input register stage: captures an item and squares the velocity magnitudes.
module snar_front import snar_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    snar_in_if.sink    i_item,
    input  logic       i_take,
    output logic       o_valid,
    output t_tick      o_tick
);

    logic        r_valid;
    t_tick       r_tick;
    t_tick       n_tick;
    logic [15:0] w_ax;
    logic [15:0] w_ay;
    logic [31:0] w_px;
    logic [31:0] w_py;

    assign i_item.ready = !r_valid || i_take;

    // 0x8000 maps to 32768, which still fits 16 unsigned bits
    assign w_ax = i_item.vel_x[15] ? (16'd0 - 16'(i_item.vel_x)) : 16'(i_item.vel_x);
    assign w_ay = i_item.vel_y[15] ? (16'd0 - 16'(i_item.vel_y)) : 16'(i_item.vel_y);
    assign w_px = w_ax * w_ax;
    assign w_py = w_ay * w_ay;

    always_comb begin
        n_tick.opcode          = i_item.opcode;
        n_tick.press_mask      = i_item.press_mask;
        n_tick.held_mask       = i_item.held_mask;
        n_tick.enable_flag     = i_item.enable_flag;
        n_tick.auto_return_off = i_item.auto_return_off;
        n_tick.sq_x            = w_px[30:0];
        n_tick.sq_y            = w_py[30:0];
        n_tick.y_neg           = i_item.vel_y[15];
        n_tick.y_zero          = (i_item.vel_y == 16'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_tick <= n_tick;
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

// ===== hdl/snar_core.sv =====
// Navigation state update; the state registers double as the result register.
module snar_core import snar_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_tick      i_tick,
    input  t_cfg       i_cfg,
    output logic       o_take,
    snar_out_if.source o_result
);

    logic       r_out_valid;
    logic       r_nav_on,   n_nav_on;
    logic       r_no_ar,    n_no_ar;
    logic       r_pm,       n_pm;
    logic       r_prev_pm,  n_prev_pm;
    logic       r_cursor,   n_cursor;
    logic       r_left,     n_left;
    logic       r_right,    n_right;
    logic [3:0] r_td,       n_td;
    logic [3:0] r_ev,       n_ev;
    logic [7:0] r_active,   n_active;
    logic [7:0] r_stable,   n_stable;
    logic [7:0] r_lock,     n_lock;
    logic [31:0] w_sum;
    logic        w_big;
    logic [3:0]  w_pdir;
    logic [3:0]  w_dir;

    assign o_take = i_valid && (!r_out_valid || o_result.ready);

    assign w_sum  = {1'b0, i_tick.sq_x} + {1'b0, i_tick.sq_y};
    assign w_big  = w_sum > i_cfg.motion_thr;
    assign w_pdir = press_dir(i_tick.press_mask);

    always_comb begin
        n_nav_on  = r_nav_on;
        n_no_ar   = r_no_ar;
        n_pm      = r_pm;
        n_prev_pm = r_prev_pm;
        n_cursor  = r_cursor;
        n_left    = r_left;
        n_right   = r_right;
        n_td      = r_td;
        n_ev      = r_ev;
        n_active  = r_active;
        n_stable  = r_stable;
        n_lock    = r_lock;
        w_dir     = dir_of_bit(i_tick.held_mask);

        case (i_tick.opcode)
            OP_TICK: begin
                n_prev_pm = r_pm;
                n_ev      = DIR_NONE;
                if (r_nav_on) begin
                    // swing detection, or count down the lockout
                    n_left  = 1'b0;
                    n_right = 1'b0;
                    if (r_lock != 8'd0) begin
                        n_lock = r_lock - 8'd1;
                    end else begin
                        if ((i_tick.y_neg || i_tick.y_zero) && w_big) begin
                            if (!r_pm) n_lock = i_cfg.gest_lockout;
                            else       n_left = 1'b1;
                        end
                        if (!i_tick.y_neg && w_big) begin
                            if (!r_pm) n_lock = i_cfg.gest_lockout;
                            else       n_right = 1'b1;
                        end
                    end

                    if (w_big) begin
                        n_active = 8'd0;
                        n_pm     = 1'b1;
                    end else if (r_pm) begin
                        if (i_tick.press_mask != 8'd0) begin
                            n_td     = w_pdir;
                            n_ev     = w_pdir;
                            n_active = i_cfg.nav_timeout;
                            n_stable = i_cfg.init_delay;
                            n_pm     = 1'b0;
                        end
                    end else begin
                        if (r_td != DIR_NONE && w_dir == r_td) begin
                            n_active = i_cfg.nav_timeout;
                            if (r_stable == 8'd0) begin
                                n_ev     = r_td;
                                n_stable = i_cfg.repeat_delay;
                            end else begin
                                n_stable = r_stable - 8'd1;
                            end
                        end else if (i_tick.press_mask != 8'd0) begin
                            w_dir    = w_pdir;
                            n_stable = i_cfg.init_delay;
                            n_td     = w_pdir;
                            n_ev     = w_pdir;
                            n_active = i_cfg.nav_timeout;
                        end else begin
                            n_td     = DIR_NONE;
                            n_stable = 8'd0;
                        end

                        // idle timeout acts on the values just computed
                        if (!r_no_ar) begin
                            if (n_active == 8'd0) begin
                                if (w_dir != DIR_NONE && n_td == w_dir) begin
                                    n_active = i_cfg.nav_timeout;
                                end else if (w_dir == DIR_NONE) begin
                                    n_td = DIR_NONE;
                                    n_pm = 1'b1;
                                end else begin
                                    n_stable = i_cfg.init_delay;
                                    n_td     = w_dir;
                                    n_ev     = w_dir;
                                    n_active = i_cfg.nav_timeout;
                                end
                            end else begin
                                n_active = n_active - 8'd1;
                            end
                        end
                    end
                end
            end
            OP_SETNAV: begin
                n_nav_on = i_tick.enable_flag;
                n_pm     = 1'b1;
                n_cursor = i_tick.enable_flag;
                n_no_ar  = i_tick.enable_flag && i_tick.auto_return_off;
            end
            OP_STOP: begin
                n_active = 8'd0;
                n_pm     = 1'b1;
            end
            OP_HIDE: begin
                n_pm = 1'b0;
            end
            OP_SCROLL: begin
                n_stable = i_cfg.repeat_delay;
                n_active = i_cfg.nav_timeout;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_nav_on    <= 1'b0;
            r_no_ar     <= 1'b0;
            r_pm        <= 1'b1;
            r_prev_pm   <= 1'b1;
            r_cursor    <= 1'b0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_td        <= DIR_NONE;
            r_ev        <= DIR_NONE;
            r_active    <= 8'd0;
            r_stable    <= 8'd0;
            r_lock      <= 8'd0;
        end else begin
            if (!r_out_valid || o_result.ready) begin
                r_out_valid <= i_valid;
            end
            if (o_take) begin
                r_nav_on  <= n_nav_on;
                r_no_ar   <= n_no_ar;
                r_pm      <= n_pm;
                r_prev_pm <= n_prev_pm;
                r_cursor  <= n_cursor;
                r_left    <= n_left;
                r_right   <= n_right;
                r_td      <= n_td;
                r_ev      <= n_ev;
                r_active  <= n_active;
                r_stable  <= n_stable;
                r_lock    <= n_lock;
            end
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.nav_event          = r_ev;
    assign o_result.held_direction     = r_td;
    assign o_result.pointer_shown      = r_pm;
    assign o_result.pointer_was_shown  = r_prev_pm;
    assign o_result.swing_left         = r_left;
    assign o_result.swing_right        = r_right;
    assign o_result.stick_cursor_shown = r_cursor;

    // an event always names the tracked direction
    a_event_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ev == DIR_NONE) || (r_ev == r_td))
        else $error("nav event differs from tracked direction");

    // swings are never reported while the lockout runs
    a_lockout_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lock != 8'd0) |-> (!r_left && !r_right))
        else $error("swing flag set during gesture lockout");

    a_prev_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_tick.opcode == OP_TICK) |=> (r_prev_pm == $past(r_pm)))
        else $error("pointer_was_shown not captured on tick");

    a_nav_off_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_tick.opcode == OP_TICK && !r_nav_on)
        |=> (r_ev == DIR_NONE && $stable(r_td) && $stable(r_lock)))
        else $error("tick changed navigation while disabled");

endmodule

// ===== hdl/stick_nav_auto_repeat.sv =====
// Top level of stick navigation with auto-repeat, pointer mode and swing gestures.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+-------------------------------------------
//  i_item    | in  | valid/ready          | opcode, masks, vel_x/vel_y, set-nav flags
//  o_result  | out | valid/ready          | nav_event, held_direction, pointer/swing bits
//  i_cfg_*   | in  | write enable only    | register index, 32-bit write data
//
//  One item per cycle sustained while o_result is not stalled; results are registered.
//  Stage one registers the item and the squared velocities (16x16 multipliers),
//  stage two sums, compares and updates state into the result register.
//  Synchronous active-low reset; no clearing pass, ready right after reset.
//  A stalled result holds stage two; stage one takes one more item only if empty.
module stick_nav_auto_repeat import snar_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    snar_in_if.sink               i_item,
    snar_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_valid;
    logic  w_take;
    t_tick w_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_delay   <= RST_INIT_DELAY;
            r_cfg.repeat_delay <= RST_REPEAT_DELAY;
            r_cfg.nav_timeout  <= RST_NAV_TIMEOUT;
            r_cfg.gest_lockout <= RST_GEST_LOCKOUT;
            r_cfg.motion_thr   <= RST_MOTION_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INIT_DELAY:   r_cfg.init_delay   <= i_cfg_data[7:0];
                CFG_REPEAT_DELAY: r_cfg.repeat_delay <= i_cfg_data[7:0];
                CFG_NAV_TIMEOUT:  r_cfg.nav_timeout  <= i_cfg_data[7:0];
                CFG_GEST_LOCKOUT: r_cfg.gest_lockout <= i_cfg_data[7:0];
                CFG_MOTION_THR:   r_cfg.motion_thr   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    snar_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_tick  (w_tick)
    );

    snar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_tick   (w_tick),
        .i_cfg    (r_cfg),
        .o_take   (w_take),
        .o_result (o_result)
    );

endmodule
